// File: rtl/vna_pkg.sv
// Package for the vertex normal accumulator: shared widths, defaults and the item kinds.
// Used by the top level, the multiplier and the port checker.
package vna_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int ACCUM_BITS_DEF   = 44;

  localparam int MODE_W     = 2;
  localparam int IDX_W      = 10;
  localparam int POS_W      = 16;
  localparam int NORM_W     = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;

  // Shared multiplier operand width and normalisation working widths.
  localparam int MUL_W  = 32;
  localparam int R_W    = 30;
  localparam int ROOT_W = 64;
  localparam int N_W    = 32;
  localparam int DIV_W  = 48;
  localparam int FRAC_W = 15;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_FACE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

endpackage

// File: rtl/vna_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module vna_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/vna_mul.sv
// Registered signed multiplier shared by the cross product and the sum of squares.
// Depends on vna_pkg for the operand width.
module vna_mul
  import vna_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_W-1:0]   a_i,
  input  logic signed [MUL_W-1:0]   b_i,
  output logic signed [2*MUL_W-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// File: rtl/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: sequencer, position and accumulator stores.
// Depends on vna_pkg, vna_ram and vna_mul.
//
// Channel   Dir  Fields (lowest bits first)
// s_axis    in   tuser: mode; tdata: vertex_index, pos_x, pos_y, pos_z,
//                corner_a, corner_b, corner_c
// m_axis    out  tdata: normal_x, normal_y, normal_z, saturated, zero padding
//
// A load does not stall the input. A face keeps the input stalled through the position reads,
// six passes through the shared multiplier and three read-modify-writes of the accumulator store.
// A query keeps the input stalled through the one-bit-a-cycle range shift, the 32-step square root
// and three 16-step restoring divisions; a zero normal ends after the square root, and an
// out-of-range query ends without any of these steps.
// After reset the accumulator store is cleared one entry a cycle, every entry,
// before the first transfer is accepted. s_axis_tready is high only while the block is idle.
// A result waits in the output register while m_axis_tready is low.
module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int ACCUM_BITS   = ACCUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: vertex_index[9:0], pos_x[25:10], pos_y[41:26], pos_z[57:42],
  //        corner_a[67:58], corner_b[77:68], corner_c[87:78]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: normal_x[15:0], normal_y[31:16], normal_z[47:32], saturated[48], zero[55:49]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB  = COORD_BITS;
  localparam int EW  = CB + 1;
  localparam int FW  = 2 * CB + 2;
  localparam int AB  = ACCUM_BITS;
  localparam int SW  = ((AB > FW) ? AB : FW) + 1;
  localparam int ARW = 3 * AB + 1;
  localparam int PRW = 3 * CB;
  localparam logic [SW-1:0] AccMax = {{(SW-AB+1){1'b0}}, {(AB-1){1'b1}}};
  localparam logic [SW-1:0] AccMin = {{(SW-AB+1){1'b1}}, {(AB-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FREAD, ST_XMUL, ST_XACC, ST_ARD, ST_AWR, ST_QRD,
    ST_QLAT, ST_QSHIFT, ST_SQMUL, ST_SQACC, ST_ROOT, ST_RCHK, ST_DINIT, ST_DIV
  } state_e;

  // A result waiting for the output register is held by the flag out_pend_q below, not by a state.
  state_e state_q;
  logic   out_pend_q;
  logic [AW-1:0] clr_q;
  logic [4:0]    cnt_q;
  logic [2:0]    k_q;
  logic          out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Input field unpacking.
  logic [IDX_W-1:0] in_vi, in_ca, in_cb, in_cc;
  logic [POS_W-1:0] in_px, in_py, in_pz;
  logic signed [CB-1:0] in_sx, in_sy, in_sz;
  mode_e in_mode;
  logic  in_acc, vi_ok, face_ok;
  logic  do_load, do_face, do_query, do_query_bad;

  assign in_vi = s_axis_tdata[9:0];
  assign in_px = s_axis_tdata[25:10];
  assign in_py = s_axis_tdata[41:26];
  assign in_pz = s_axis_tdata[57:42];
  assign in_ca = s_axis_tdata[67:58];
  assign in_cb = s_axis_tdata[77:68];
  assign in_cc = s_axis_tdata[87:78];
  assign in_mode = mode_e'(s_axis_tuser);
  // Coordinates are the low COORD_BITS bits of the field, read as two's complement.
  assign in_sx = CB'(32'(in_px));
  assign in_sy = CB'(32'(in_py));
  assign in_sz = CB'(32'(in_pz));

  assign vi_ok   = 32'(in_vi) < MAX_VERTICES;
  assign face_ok = (32'(in_ca) < MAX_VERTICES) && (32'(in_cb) < MAX_VERTICES)
                   && (32'(in_cc) < MAX_VERTICES);

  assign s_axis_tready = (state_q == ST_IDLE) && !out_pend_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign do_load       = in_acc && (in_mode == MODE_LOAD) && vi_ok;
  assign do_face       = in_acc && (in_mode == MODE_FACE) && face_ok;
  assign do_query      = in_acc && (in_mode == MODE_QUERY) && vi_ok;
  assign do_query_bad  = in_acc && (in_mode == MODE_QUERY) && !vi_ok;

  // Datapath registers.
  logic [AW-1:0]        idx_q [3];
  logic signed [CB-1:0] pos_q [3][3];
  logic signed [FW-1:0] f_q [3];
  logic signed [AB-1:0] acc_q [3];
  logic                 sat_q;
  logic [AB-1:0]        m_q [3];
  logic [ROOT_W-1:0]    sum_q, v_q, res_q, bit_q;
  logic [DIV_W-1:0]     rem_q, dsh_q;
  logic [NORM_W-1:0]    quo_q;
  logic [NORM_W-1:0]    norm_q [3];

  // Edge vectors of the face, from the latched corner positions.
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EW'(pos_q[1][i]) - EW'(pos_q[0][i]);
      e2[i] = EW'(pos_q[2][i]) - EW'(pos_q[0][i]);
    end
  end

  // Shared multiplier operand selection.
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [R_W-1:0]            sq_op;

  assign sq_op = m_q[k_q[1:0]][R_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQMUL) begin
      mul_a = MUL_W'(sq_op);
      mul_b = MUL_W'(sq_op);
    end else begin
      case (k_q)
        3'd0: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[2]); end
        3'd1: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[1]); end
        3'd2: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[0]); end
        3'd3: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[2]); end
        3'd4: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[1]); end
        3'd5: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  vna_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Position store.
  logic           pos_we;
  logic [AW-1:0]  pos_waddr, pos_raddr;
  logic [PRW-1:0] pos_wdata, pos_rdata;

  assign pos_we    = do_load;
  assign pos_waddr = AW'(32'(in_vi));
  assign pos_wdata = {in_sz, in_sy, in_sx};
  assign pos_raddr = idx_q[cnt_q[1:0]];

  vna_ram #(.Width(PRW), .Depth(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Accumulator store: {saturated, z, y, x}.
  logic           acc_we;
  logic [AW-1:0]  acc_waddr, acc_raddr;
  logic [ARW-1:0] acc_wdata, acc_rdata;
  logic signed [AB-1:0] rd_acc [3];
  logic signed [AB-1:0] new_acc [3];
  logic [2:0]           sat_hit;

  assign rd_acc[0] = acc_rdata[AB-1:0];
  assign rd_acc[1] = acc_rdata[2*AB-1:AB];
  assign rd_acc[2] = acc_rdata[3*AB-1:2*AB];

  // Saturating add of one cross-product component to each accumulator lane.
  always_comb begin
    logic signed [SW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = SW'(rd_acc[i]) + SW'(f_q[i]);
      sat_hit[i] = 1'b0;
      new_acc[i] = AB'(s);
      if (s > signed'(AccMax)) begin
        new_acc[i] = AB'(AccMax);
        sat_hit[i] = 1'b1;
      end else if (s < signed'(AccMin)) begin
        new_acc[i] = AB'(AccMin);
        sat_hit[i] = 1'b1;
      end
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = idx_q[k_q[1:0]];
    acc_wdata = {acc_rdata[3*AB] | (|sat_hit), new_acc[2], new_acc[1], new_acc[0]};
    if (state_q == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_q;
      acc_wdata = '0;
    end else if (do_load) begin
      acc_we    = 1'b1;
      acc_waddr = AW'(32'(in_vi));
      acc_wdata = '0;
    end else if (state_q == ST_AWR) begin
      acc_we = 1'b1;
    end
  end

  assign acc_raddr = (state_q == ST_ARD) ? idx_q[k_q[1:0]] : idx_q[0];

  vna_ram #(.Width(ARW), .Depth(MAX_VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Square-root and division step logic.
  logic [ROOT_W-1:0] rt_t;
  logic              rt_ge, dv_ge;
  logic [NORM_W-1:0] quo_fin, norm_fin;
  logic [N_W-1:0]    n_val;
  logic              range_hi;

  assign rt_t     = res_q + bit_q;
  assign rt_ge    = v_q >= rt_t;
  assign dv_ge    = rem_q >= dsh_q;
  assign quo_fin  = {quo_q[NORM_W-2:0], dv_ge};
  assign n_val    = res_q[N_W-1:0];
  assign range_hi = (m_q[0] | m_q[1] | m_q[2]) >= AB'(64'(1) << R_W);

  // Sign and clamp of the rounded quotient.
  always_comb begin
    if (acc_q[k_q[1:0]][AB-1]) begin
      norm_fin = NORM_W'(~quo_fin + 1'b1);
    end else if (quo_fin[NORM_W-1]) begin
      norm_fin = {1'b0, {(NORM_W-1){1'b1}}};
    end else begin
      norm_fin = quo_fin;
    end
  end

  // Sequencer: state, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_pend_q  <= 1'b0;
      clr_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_pend_q && (!out_valid_q || m_axis_tready)) begin
        out_pend_q  <= 1'b0;
        out_valid_q <= 1'b1;
        out_data_q  <= {{(OUT_DATA_W-3*NORM_W-1){1'b0}}, sat_q,
                        norm_q[2], norm_q[1], norm_q[0]};
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_VERTICES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt_q <= '0;
          k_q   <= '0;
          if (do_face) begin
            state_q <= ST_FREAD;
          end else if (do_query) begin
            state_q <= ST_QRD;
          end else if (do_query_bad) begin
            out_pend_q <= 1'b1;
          end
        end
        ST_FREAD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd3) begin
            state_q <= ST_XMUL;
          end
        end
        ST_XMUL: state_q <= ST_XACC;
        ST_XACC: begin
          if (k_q == 3'd5) begin
            k_q     <= '0;
            state_q <= ST_ARD;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_XMUL;
          end
        end
        ST_ARD: state_q <= ST_AWR;
        ST_AWR: begin
          if (k_q == 3'd2) begin
            state_q <= ST_IDLE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_ARD;
          end
        end
        ST_QRD:  state_q <= ST_QLAT;
        ST_QLAT: state_q <= ST_QSHIFT;
        ST_QSHIFT: begin
          if (!range_hi) begin
            k_q     <= '0;
            state_q <= ST_SQMUL;
          end
        end
        ST_SQMUL: state_q <= ST_SQACC;
        ST_SQACC: begin
          if (k_q == 3'd2) begin
            cnt_q   <= 5'd31;
            state_q <= ST_ROOT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SQMUL;
          end
        end
        ST_ROOT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 5'd0) begin
            state_q <= ST_RCHK;
          end
        end
        ST_RCHK: begin
          k_q <= '0;
          if (res_q == '0) begin
            out_pend_q <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            state_q <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          cnt_q   <= 5'(NORM_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 5'd0) begin
            if (k_q == 3'd2) begin
              out_pend_q <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_DINIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, loaded under the sequencer's state.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q[0] <= (in_mode == MODE_FACE) ? AW'(32'(in_ca)) : AW'(32'(in_vi));
      idx_q[1] <= AW'(32'(in_cb));
      idx_q[2] <= AW'(32'(in_cc));
      if (do_query_bad) begin
        sat_q <= 1'b0;
        for (int i = 0; i < 3; i++) norm_q[i] <= '0;
      end
    end
    case (state_q)
      ST_FREAD: begin
        if (cnt_q != 5'd0) begin
          pos_q[cnt_q[1:0] - 2'd1][0] <= pos_rdata[CB-1:0];
          pos_q[cnt_q[1:0] - 2'd1][1] <= pos_rdata[2*CB-1:CB];
          pos_q[cnt_q[1:0] - 2'd1][2] <= pos_rdata[3*CB-1:2*CB];
        end
      end
      ST_XACC: begin
        if (k_q[0]) begin
          f_q[k_q[2:1]] <= f_q[k_q[2:1]] - FW'(mul_p);
        end else begin
          f_q[k_q[2:1]] <= FW'(mul_p);
        end
      end
      ST_QLAT: begin
        sat_q <= acc_rdata[3*AB];
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= rd_acc[i];
          m_q[i]   <= rd_acc[i][AB-1] ? AB'(~rd_acc[i] + 1'b1) : AB'(rd_acc[i]);
        end
        sum_q <= '0;
      end
      ST_QSHIFT: begin
        if (range_hi) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end
      end
      ST_SQACC: begin
        sum_q <= sum_q + ROOT_W'(mul_p);
        v_q   <= sum_q + ROOT_W'(mul_p);
        res_q <= '0;
        bit_q <= ROOT_W'(64'(1) << 62);
      end
      ST_ROOT: begin
        if (rt_ge) begin
          v_q   <= v_q - rt_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_RCHK: begin
        if (res_q == '0) begin
          for (int i = 0; i < 3; i++) norm_q[i] <= '0;
        end
      end
      ST_DINIT: begin
        rem_q <= (DIV_W'(m_q[k_q[1:0]][R_W-1:0]) << FRAC_W) + DIV_W'(n_val >> 1);
        dsh_q <= DIV_W'(n_val) << FRAC_W;
        quo_q <= '0;
      end
      ST_DIV: begin
        if (dv_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_fin;
        if (cnt_q == 5'd0) begin
          norm_q[k_q[1:0]] <= norm_fin;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/vna_checker.sv
// Port-level checker for the vertex normal accumulator, bound to the top level.
// Depends on vna_pkg for the channel widths and item kinds.
module vna_checker
  import vna_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [MODE_W-1:0]     s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A query keeps the block busy in the cycle after its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
    else $error("block ready right after a query");

  // A new result appears only after the block has been busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // Padding bits above the saturation flag stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:3*NORM_W+1] == '0))
    else $error("nonzero padding in result");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);
